FILE: rtl/cau_pkg.sv
// cau_pkg: shared constants, types and the saturation helper
// for the complex arithmetic unit; no dependencies
package cau_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DIV_STEPS  = 32;
  localparam int PIPE_DEPTH = 5 + DIV_STEPS;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  typedef struct packed {
    logic        val;
    logic [31:0] word;
  } sat_t;

  typedef struct packed {
    logic        valid;
    logic        is_div;
    logic        dz;
    logic        neg_re;
    logic        neg_im;
    logic        big_re;
    logic        big_im;
    logic [31:0] res_re;
    logic [31:0] res_im;
    logic [1:0]  st;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [63:0] den;
    logic [63:0] rem_re;
    logic [63:0] rem_im;
    logic [31:0] bits_re;
    logic [31:0] bits_im;
    logic [31:0] q_re;
    logic [31:0] q_im;
  } cell_t;

  function automatic sat_t sat32(input logic neg, input logic [63:0] mag);
    sat_t r;
    r.val = 1'b0;
    if (neg) begin
      if (mag > {32'd0, NEG_LIMIT}) begin
        r.val  = 1'b1;
        r.word = NEG_LIMIT;
      end else begin
        r.word = (~mag[31:0]) + 32'd1;
      end
    end else begin
      if (mag > {32'd0, POS_LIMIT}) begin
        r.val  = 1'b1;
        r.word = POS_LIMIT;
      end else begin
        r.word = mag[31:0];
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/complex_arith_unit_top.sv
// complex_arith_unit_top: complex add, subtract, multiply, divide in Q16.16
// instantiates cau_front and a chain of cau_div_cell; depends on cau_pkg
//
// A word is taken on every cycle that start is high (busy stays low), and its
// result appears on the out_ ports for one cycle with out_valid after passing,
// for every op, through three front stages, one prep stage, the 32-cell
// division chain (one quotient bit per cell) and the output register. The
// receiver cannot stall, so results must be taken when out_valid is high.
module complex_arith_unit_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_a_real,
  input  logic signed [31:0] in_a_imag,
  input  logic signed [31:0] in_b_real,
  input  logic signed [31:0] in_b_imag,
  output logic               out_valid,
  output logic signed [31:0] out_r_real,
  output logic signed [31:0] out_r_imag,
  output logic [1:0]         out_status
);

  logic acc;
  cau_pkg::cell_t chain [cau_pkg::DIV_STEPS+1];

  logic        out_valid_r;
  logic [31:0] out_re_r, out_im_r, out_re_nxt, out_im_nxt;
  logic [1:0]  out_st_r, out_st_nxt;

  assign busy = 1'b0;
  assign acc  = start && !busy && rst_n;

  cau_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .op     (in_op),
    .a_real (in_a_real),
    .a_imag (in_a_imag),
    .b_real (in_b_real),
    .b_imag (in_b_imag),
    .cell_o (chain[0])
  );

  for (genvar g = 0; g < cau_pkg::DIV_STEPS; g++) begin : g_cell
    cau_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  always_comb begin
    cau_pkg::cell_t c;
    cau_pkg::sat_t  s_re, s_im;
    c    = chain[cau_pkg::DIV_STEPS];
    s_re = cau_pkg::sat32(c.side.neg_re, {31'd0, c.side.big_re, c.q_re});
    s_im = cau_pkg::sat32(c.side.neg_im, {31'd0, c.side.big_im, c.q_im});
    if (!c.side.is_div) begin
      out_re_nxt = c.side.res_re;
      out_im_nxt = c.side.res_im;
      out_st_nxt = c.side.st;
    end else if (c.side.dz) begin
      out_re_nxt = 32'd0;
      out_im_nxt = 32'd0;
      out_st_nxt = cau_pkg::ST_DZ;
    end else begin
      out_re_nxt = s_re.word;
      out_im_nxt = s_im.word;
      out_st_nxt = (s_re.val || s_im.val) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain[cau_pkg::DIV_STEPS].side.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_re_r <= out_re_nxt;
    out_im_r <= out_im_nxt;
    out_st_r <= out_st_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_r_real = out_re_r;
  assign out_r_imag = out_im_r;
  assign out_status = out_st_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(acc, cau_pkg::PIPE_DEPTH))
    else $error("result strobe does not follow accepted word");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == cau_pkg::ST_DZ) |-> (out_r_real == 0 && out_r_imag == 0))
    else $error("divide by zero result not zero");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == cau_pkg::ST_SAT) |->
      (out_r_real == cau_pkg::POS_LIMIT || out_r_real == cau_pkg::NEG_LIMIT ||
       out_r_imag == cau_pkg::POS_LIMIT || out_r_imag == cau_pkg::NEG_LIMIT))
    else $error("saturated status without a limit value");

endmodule

FILE: rtl/cau_front.sv
// cau_front: operand capture, products, sums and magnitude prep
// feeds the division cell chain; depends on cau_pkg
module cau_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [1:0]         op,
  input  logic signed [31:0] a_real,
  input  logic signed [31:0] a_imag,
  input  logic signed [31:0] b_real,
  input  logic signed [31:0] b_imag,
  output cau_pkg::cell_t     cell_o
);

  // stage 1
  logic               v1_r;
  logic [1:0]         op1_r;
  logic signed [31:0] ar_r, ai_r, br_r, bi_r;

  // stage 2
  logic               v2_r;
  logic [1:0]         op2_r;
  logic signed [63:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic [63:0]        s_rr_r, s_ii_r;
  logic [32:0]        sum_re_r, sum_im_r;
  logic [32:0]        sum_re_nxt, sum_im_nxt;

  // stage 3
  logic        v3_r;
  logic [1:0]  op3_r;
  logic [65:0] v_re_r, v_im_r;
  logic [63:0] den_r;
  logic [65:0] v_re_nxt, v_im_nxt;

  // stage 4
  cau_pkg::cell_t cell_r, cell_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      cell_r.side.valid <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      cell_r.side.valid <= cell_nxt.side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op1_r <= op;
      ar_r  <= a_real;
      ai_r  <= a_imag;
      br_r  <= b_real;
      bi_r  <= b_imag;
    end
  end

  always_comb begin
    if (op1_r == cau_pkg::OP_SUB) begin
      sum_re_nxt = {ar_r[31], ar_r} - {br_r[31], br_r};
      sum_im_nxt = {ai_r[31], ai_r} - {bi_r[31], bi_r};
    end else begin
      sum_re_nxt = {ar_r[31], ar_r} + {br_r[31], br_r};
      sum_im_nxt = {ai_r[31], ai_r} + {bi_r[31], bi_r};
    end
  end

  always_ff @(posedge clk) begin
    op2_r    <= op1_r;
    p_rr_r   <= ar_r * br_r;
    p_ii_r   <= ai_r * bi_r;
    p_ri_r   <= ar_r * bi_r;
    p_ir_r   <= ai_r * br_r;
    s_rr_r   <= br_r * br_r;
    s_ii_r   <= bi_r * bi_r;
    sum_re_r <= sum_re_nxt;
    sum_im_r <= sum_im_nxt;
  end

  always_comb begin
    logic [65:0] e_rr, e_ii, e_ri, e_ir;
    e_rr = {{2{p_rr_r[63]}}, p_rr_r};
    e_ii = {{2{p_ii_r[63]}}, p_ii_r};
    e_ri = {{2{p_ri_r[63]}}, p_ri_r};
    e_ir = {{2{p_ir_r[63]}}, p_ir_r};
    unique case (op2_r)
      cau_pkg::OP_MUL: begin
        v_re_nxt = e_rr - e_ii;
        v_im_nxt = e_ri + e_ir;
      end
      cau_pkg::OP_DIV: begin
        v_re_nxt = e_rr + e_ii;
        v_im_nxt = e_ir - e_ri;
      end
      default: begin
        v_re_nxt = {{33{sum_re_r[32]}}, sum_re_r};
        v_im_nxt = {{33{sum_im_r[32]}}, sum_im_r};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op3_r  <= op2_r;
    v_re_r <= v_re_nxt;
    v_im_r <= v_im_nxt;
    den_r  <= s_rr_r + s_ii_r;
  end

  always_comb begin
    logic [65:0] m_re66, m_im66;
    logic [63:0] m_re, m_im, f_re, f_im;
    logic [63+cau_pkg::FRAC_BITS:0] n_re, n_im;
    logic [95:0] den_sh;
    cau_pkg::sat_t s_re, s_im;
    m_re66 = v_re_r[65] ? (~v_re_r + 66'd1) : v_re_r;
    m_im66 = v_im_r[65] ? (~v_im_r + 66'd1) : v_im_r;
    m_re   = m_re66[63:0];
    m_im   = m_im66[63:0];
    if (op3_r == cau_pkg::OP_MUL) begin
      f_re = m_re >> cau_pkg::FRAC_BITS;
      f_im = m_im >> cau_pkg::FRAC_BITS;
    end else begin
      f_re = m_re;
      f_im = m_im;
    end
    s_re = cau_pkg::sat32(v_re_r[65], f_re);
    s_im = cau_pkg::sat32(v_im_r[65], f_im);
    n_re   = {m_re, {cau_pkg::FRAC_BITS{1'b0}}};
    n_im   = {m_im, {cau_pkg::FRAC_BITS{1'b0}}};
    den_sh = {32'd0, den_r} << (32 - cau_pkg::FRAC_BITS);

    cell_nxt.side.valid  = v3_r;
    cell_nxt.side.is_div = (op3_r == cau_pkg::OP_DIV);
    cell_nxt.side.dz     = (den_r == 64'd0);
    cell_nxt.side.neg_re = v_re_r[65];
    cell_nxt.side.neg_im = v_im_r[65];
    cell_nxt.side.big_re = ({32'd0, m_re} >= den_sh);
    cell_nxt.side.big_im = ({32'd0, m_im} >= den_sh);
    cell_nxt.side.res_re = s_re.word;
    cell_nxt.side.res_im = s_im.word;
    cell_nxt.side.st     = (s_re.val || s_im.val) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    cell_nxt.den     = den_r;
    cell_nxt.rem_re  = {{(32 - cau_pkg::FRAC_BITS){1'b0}}, n_re[63+cau_pkg::FRAC_BITS:32]};
    cell_nxt.rem_im  = {{(32 - cau_pkg::FRAC_BITS){1'b0}}, n_im[63+cau_pkg::FRAC_BITS:32]};
    cell_nxt.bits_re = n_re[31:0];
    cell_nxt.bits_im = n_im[31:0];
    cell_nxt.q_re    = 32'd0;
    cell_nxt.q_im    = 32'd0;
  end

  always_ff @(posedge clk) begin
    cell_r.side.is_div <= cell_nxt.side.is_div;
    cell_r.side.dz     <= cell_nxt.side.dz;
    cell_r.side.neg_re <= cell_nxt.side.neg_re;
    cell_r.side.neg_im <= cell_nxt.side.neg_im;
    cell_r.side.big_re <= cell_nxt.side.big_re;
    cell_r.side.big_im <= cell_nxt.side.big_im;
    cell_r.side.res_re <= cell_nxt.side.res_re;
    cell_r.side.res_im <= cell_nxt.side.res_im;
    cell_r.side.st     <= cell_nxt.side.st;
    cell_r.den         <= cell_nxt.den;
    cell_r.rem_re      <= cell_nxt.rem_re;
    cell_r.rem_im      <= cell_nxt.rem_im;
    cell_r.bits_re     <= cell_nxt.bits_re;
    cell_r.bits_im     <= cell_nxt.bits_im;
    cell_r.q_re        <= cell_nxt.q_re;
    cell_r.q_im        <= cell_nxt.q_im;
  end

  assign cell_o = cell_r;

endmodule

FILE: rtl/cau_div_cell.sv
// cau_div_cell: one restoring division step for both result parts
// one quotient bit per cell; depends on cau_pkg
module cau_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  cau_pkg::cell_t cell_i,
  output cau_pkg::cell_t cell_o
);

  cau_pkg::cell_t cell_r, cell_nxt;

  always_comb begin
    logic [63:0] sh_re, sh_im;
    cell_nxt = cell_i;
    sh_re = {cell_i.rem_re[62:0], cell_i.bits_re[31]};
    sh_im = {cell_i.rem_im[62:0], cell_i.bits_im[31]};
    cell_nxt.bits_re = {cell_i.bits_re[30:0], 1'b0};
    cell_nxt.bits_im = {cell_i.bits_im[30:0], 1'b0};
    if (sh_re >= cell_i.den) begin
      cell_nxt.rem_re = sh_re - cell_i.den;
      cell_nxt.q_re   = {cell_i.q_re[30:0], 1'b1};
    end else begin
      cell_nxt.rem_re = sh_re;
      cell_nxt.q_re   = {cell_i.q_re[30:0], 1'b0};
    end
    if (sh_im >= cell_i.den) begin
      cell_nxt.rem_im = sh_im - cell_i.den;
      cell_nxt.q_im   = {cell_i.q_im[30:0], 1'b1};
    end else begin
      cell_nxt.rem_im = sh_im;
      cell_nxt.q_im   = {cell_i.q_im[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.side.valid <= 1'b0;
    end else begin
      cell_r.side.valid <= cell_nxt.side.valid;
    end
  end

  always_ff @(posedge clk) begin
    cell_r.side.is_div <= cell_nxt.side.is_div;
    cell_r.side.dz     <= cell_nxt.side.dz;
    cell_r.side.neg_re <= cell_nxt.side.neg_re;
    cell_r.side.neg_im <= cell_nxt.side.neg_im;
    cell_r.side.big_re <= cell_nxt.side.big_re;
    cell_r.side.big_im <= cell_nxt.side.big_im;
    cell_r.side.res_re <= cell_nxt.side.res_re;
    cell_r.side.res_im <= cell_nxt.side.res_im;
    cell_r.side.st     <= cell_nxt.side.st;
    cell_r.den         <= cell_nxt.den;
    cell_r.rem_re      <= cell_nxt.rem_re;
    cell_r.rem_im      <= cell_nxt.rem_im;
    cell_r.bits_re     <= cell_nxt.bits_re;
    cell_r.bits_im     <= cell_nxt.bits_im;
    cell_r.q_re        <= cell_nxt.q_re;
    cell_r.q_im        <= cell_nxt.q_im;
  end

  assign cell_o = cell_r;

endmodule

FILE: verif/complex_arith_unit_top_tb.sv
// complex_arith_unit_top_tb: self-checking bench for the complex arithmetic unit
// drives random and directed operand words, predicts results in a queue, checks each output
// depends on cau_pkg and complex_arith_unit_top
module complex_arith_unit_top_tb;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] ar, ai, br, bi;
  } operand_t;

  typedef struct {
    logic [31:0] re, im;
    logic [1:0]  st;
  } cplx_res_t;

  localparam int WATCHDOG = 2000;

  logic clk, rst_n, start, busy;
  logic [1:0] in_op;
  logic signed [31:0] in_a_real, in_a_imag, in_b_real, in_b_imag;
  logic out_valid;
  logic signed [31:0] out_r_real, out_r_imag;
  logic [1:0] out_status;

  complex_arith_unit_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_a_real(in_a_real), .in_a_imag(in_a_imag),
    .in_b_real(in_b_real), .in_b_imag(in_b_imag),
    .out_valid(out_valid), .out_r_real(out_r_real), .out_r_imag(out_r_imag),
    .out_status(out_status)
  );

  operand_t  pending_words[$];
  cplx_res_t expected_results[$];
  int        mismatches = 0;
  int        stall_cycles = 0;
  int        gap_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // saturate a signed 130-bit value to 32 bits
  function automatic logic [31:0] clamp32(input logic signed [129:0] v, inout bit sat);
    if (v > 130'sd2147483647) begin
      sat = 1;
      return cau_pkg::POS_LIMIT;
    end
    if (v < -130'sd2147483648) begin
      sat = 1;
      return cau_pkg::NEG_LIMIT;
    end
    return v[31:0];
  endfunction

  // truncate toward zero: divide the magnitude, then restore the sign
  function automatic logic signed [129:0] trunc_div(input logic signed [129:0] n,
                                                      input logic signed [129:0] d);
    logic signed [129:0] m;
    m = (n < 0) ? -n : n;
    m = m / d;
    return (n < 0) ? -m : m;
  endfunction

  function automatic cplx_res_t complex_result(input operand_t w);
    cplx_res_t r;
    bit sat;
    logic signed [129:0] ar, ai, br, bi, re, im, den;
    sat = 0;
    ar = w.ar; ai = w.ai; br = w.br; bi = w.bi;
    r.st = cau_pkg::ST_OK;
    case (w.op)
      cau_pkg::OP_ADD: begin
        re = ar + br; im = ai + bi;
      end
      cau_pkg::OP_SUB: begin
        re = ar - br; im = ai - bi;
      end
      cau_pkg::OP_MUL: begin
        re = trunc_div(ar * br - ai * bi, 130'sd1 <<< cau_pkg::FRAC_BITS);
        im = trunc_div(ar * bi + ai * br, 130'sd1 <<< cau_pkg::FRAC_BITS);
      end
      default: begin
        den = br * br + bi * bi;
        re = 0; im = 0;
        if (den != 0) begin
          re = trunc_div((ar * br + ai * bi) <<< cau_pkg::FRAC_BITS, den);
          im = trunc_div((ai * br - ar * bi) <<< cau_pkg::FRAC_BITS, den);
        end else begin
          r.st = cau_pkg::ST_DZ;
        end
      end
    endcase
    r.re = clamp32(re, sat);
    r.im = clamp32(im, sat);
    if (r.st == cau_pkg::ST_OK && sat) r.st = cau_pkg::ST_SAT;
    return r;
  endfunction

  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 2);
      1: return 32'h8000_0000 + $urandom_range(0, 2);
      2: return $urandom_range(0, 3) << 16;
      3: return -($urandom_range(0, 'hFFFFF));
      4: return $urandom_range(0, 'hFFFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_word(input logic [1:0] op, input logic [31:0] ar, ai, br, bi);
    operand_t w;
    w.op = op; w.ar = ar; w.ai = ai; w.br = br; w.bi = bi;
    pending_words.push_back(w);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got, exp);
    mismatches++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else begin
      if (start) expected_results.push_back(complex_result(pending_words.pop_front()));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_words.size() > 0) begin
        if (pending_words.size() > 200 && $urandom_range(0, 9) == 0) begin
          gap_left <= $urandom_range(0, 11);
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          in_op <= pending_words[0].op;
          in_a_real <= pending_words[0].ar;
          in_a_imag <= pending_words[0].ai;
          in_b_real <= pending_words[0].br;
          in_b_imag <= pending_words[0].bi;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cplx_res_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", out_r_real, 32'h0);
      end else begin
        e = expected_results.pop_front();
        if (out_r_real !== e.re) report_mismatch("r_real", out_r_real, e.re);
        if (out_r_imag !== e.im) report_mismatch("r_imag", out_r_imag, e.im);
        if (out_status !== e.st) report_mismatch("status", {30'd0, out_status}, {30'd0, e.st});
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WATCHDOG) begin
      $display("[complex_arith_unit_top] ERROR");
      $finish;
    end
  end

  initial begin
    logic [31:0] mx, mn;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = cau_pkg::OP_ADD;
    in_a_real = 0; in_a_imag = 0; in_b_real = 0; in_b_imag = 0;
    mx = 32'h7FFF_FFFF; mn = 32'h8000_0000;
    for (int op = 0; op < 4; op++) begin
      add_word(2'(op), mx, mx, mx, mx);
      add_word(2'(op), mn, mn, mn, mn);
      add_word(2'(op), mx, mn, mn, mx);
      add_word(2'(op), 32'h0001_8000, 32'hFFFE_8000, 32'h0002_0000, 32'hFFFF_0000);
      add_word(2'(op), 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0);
    end
    add_word(cau_pkg::OP_DIV, mx, mn, 32'h0, 32'h1);
    add_word(cau_pkg::OP_DIV, 32'h1, 32'hFFFF_FFFF, mn, mn);
    add_word(cau_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 1900; i++) begin
      add_word(2'($urandom_range(0, 3)), rand_part(), rand_part(),
               ($urandom_range(0, 30) == 0) ? 32'h0 : rand_part(),
               ($urandom_range(0, 30) == 0) ? 32'h0 : rand_part());
      if (i % 200 == 0) @(posedge clk);
    end
    wait (pending_words.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (cau_pkg::PIPE_DEPTH + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[complex_arith_unit_top] OK");
    end else begin
      $display("[complex_arith_unit_top] ERROR");
    end
    $finish;
  end

endmodule
